>>> sv/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared types, constants and helpers of the chunked body decoder
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

  // width of the chunk size and of the per-chunk byte counters
  localparam int unsigned SIZE_BITS         = 32;
  // size lines this long or longer are malformed
  localparam int unsigned LINE_BUFFER_BYTES = 32;
  localparam int unsigned LEN_BITS          = 6;
  localparam logic [LEN_BITS-1:0] LEN_CAP   = '1;
  localparam int unsigned DC_BITS           = 32;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [1:0] SKIP_BYTES = 2'd2;

  typedef enum logic [1:0] {
    PH_LINE = 2'd0,
    PH_DATA = 2'd1,
    PH_SKIP = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_TERM   = 2'd0,
    ST_NOTERM = 2'd1,
    ST_TRUNC  = 2'd2,
    ST_BAD    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               out_valid;
    logic               body_done;
    status_t            end_status;
    logic [DC_BITS-1:0] discard_count;
  } out_item_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t d;
    d.is_hex = 1'b1;
    d.value  = 4'd0;
    if (c >= "0" && c <= "9") begin
      d.value = 4'(c - 8'h30);
    end else if (c >= "a" && c <= "f") begin
      d.value = 4'(c - 8'h57);
    end else if (c >= "A" && c <= "F") begin
      d.value = 4'(c - 8'h37);
    end else begin
      d.is_hex = 1'b0;
    end
    return d;
  endfunction

  function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] len);
    return (len == LEN_CAP) ? len : len + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> sv/hcbd_in_if.sv
// ----------------------------------------------------------------------------
// hcbd_in_if
// input channel of the chunked body decoder: raw body bytes
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbd_in_if import hcbd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/hcbd_out_if.sv
// ----------------------------------------------------------------------------
// hcbd_out_if
// result channel of the chunked body decoder: one result per input byte
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbd_out_if import hcbd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/http_chunked_body_decoder_top.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// streaming decoder for an http/1.1 chunked transfer-coded body
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries the raw body one byte per transaction, with in_last set on
//   the final byte of the body. out_ch returns exactly one result transaction
//   per input byte: the payload byte with out_valid when the byte was chunk
//   data, and on the final byte body_done, end_status and discard_count.
//   each result is registered. throughput: one byte per cycle while the skid
//   register is free; the decode state is updated in the same cycle the byte
//   is accepted, so consecutive bytes need no gaps.
//   stall: the result register is backed by a one-entry skid register, so a
//   byte is still taken in the first cycle out_ch stalls; in_ch.ready drops
//   only once the skid register holds a result, and rises again as soon as
//   the receiver takes the waiting one.
//   reset: rst_n is synchronous, active low; it clears the decode state to
//   the start of a size line and empties both result registers. The decode
//   state also returns to that point after every final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder_top import hcbd_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  hcbd_in_if.sink    in_ch,
  hcbd_out_if.source out_ch
);

  // decode state
  phase_t                phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]  hex_value_r, hex_value_nxt;
  logic                  hex_ended_r, hex_ended_nxt;
  logic [LEN_BITS-1:0]   line_length_r, line_length_nxt;
  logic                  pending_cr_r, pending_cr_nxt;
  logic [SIZE_BITS-1:0]  chunk_remaining_r, chunk_remaining_nxt;
  logic [SIZE_BITS-1:0]  chunk_emitted_r, chunk_emitted_nxt;
  logic [1:0]            skip_left_r, skip_left_nxt;
  status_t               stop_reason_r, stop_reason_nxt;

  // result register and skid register
  out_item_t out_r, skid_r;
  logic      out_vld_r, skid_vld_r;
  out_item_t res;

  logic       accept;
  logic [7:0] c;
  logic       last;

  // phase after this byte, before the end-of-body reset
  phase_t               ph_step;
  logic [SIZE_BITS-1:0] rem_step;
  logic [SIZE_BITS-1:0] emit_step;
  status_t              stop_step;

  hex_digit_t             dig;
  logic [SIZE_BITS+3:0]   hex_shift;
  logic [LEN_BITS-1:0]    len_tmp;

  assign c      = in_ch.payload.in_byte;
  assign last   = in_ch.payload.in_last;
  assign accept = in_ch.valid & in_ch.ready;

  // taken while the skid register is free
  assign in_ch.ready    = ~skid_vld_r;
  assign out_ch.valid   = out_vld_r;
  assign out_ch.payload = out_r;

  assign dig       = hex_digit(c);
  assign hex_shift = {hex_value_r, 4'd0} + {{SIZE_BITS{1'b0}}, dig.value};

  // next state of the decoder
  always_comb begin
    phase_nxt           = phase_r;
    hex_value_nxt       = hex_value_r;
    hex_ended_nxt       = hex_ended_r;
    line_length_nxt     = line_length_r;
    pending_cr_nxt      = pending_cr_r;
    chunk_remaining_nxt = chunk_remaining_r;
    chunk_emitted_nxt   = chunk_emitted_r;
    skip_left_nxt       = skip_left_r;
    stop_reason_nxt     = stop_reason_r;
    len_tmp             = line_length_r;

    case (phase_r)
      PH_LINE: begin
        if (pending_cr_r && c == CH_LF) begin
          // CR LF closes the size line
          pending_cr_nxt = 1'b0;
          if (line_length_r == '0 ||
              line_length_r >= LEN_BITS'(LINE_BUFFER_BYTES)) begin
            phase_nxt       = PH_STOP;
            stop_reason_nxt = ST_BAD;
          end else if (hex_value_r == '0) begin
            phase_nxt       = PH_STOP;
            stop_reason_nxt = ST_TERM;
          end else begin
            phase_nxt           = PH_DATA;
            chunk_remaining_nxt = hex_value_r;
            chunk_emitted_nxt   = '0;
          end
          hex_value_nxt   = '0;
          hex_ended_nxt   = 1'b0;
          line_length_nxt = '0;
        end else begin
          // a lone CR counts as a line byte once the next byte shows up
          if (pending_cr_r) begin
            len_tmp = len_inc(len_tmp);
          end
          if (c == CH_CR) begin
            pending_cr_nxt = 1'b1;
          end else begin
            pending_cr_nxt = 1'b0;
            len_tmp        = len_inc(len_tmp);
          end
          line_length_nxt = len_tmp;
          if (!hex_ended_r) begin
            if (!dig.is_hex) begin
              hex_ended_nxt = 1'b1;
            end else if (hex_shift[SIZE_BITS+3:SIZE_BITS] != 4'd0) begin
              hex_value_nxt = '1;
            end else begin
              hex_value_nxt = hex_shift[SIZE_BITS-1:0];
            end
          end
        end
      end
      PH_DATA: begin
        if (chunk_remaining_r != '0) begin
          chunk_remaining_nxt = chunk_remaining_r - 1'b1;
        end
        chunk_emitted_nxt = chunk_emitted_r + 1'b1;
        if (chunk_remaining_r <= SIZE_BITS'(1)) begin
          phase_nxt     = PH_SKIP;
          skip_left_nxt = SKIP_BYTES;
        end
      end
      PH_SKIP: begin
        if (skip_left_r != 2'd0) begin
          skip_left_nxt = skip_left_r - 1'b1;
        end
        if (skip_left_r <= 2'd1) begin
          phase_nxt = PH_LINE;
        end
      end
      default: begin
      end
    endcase

    ph_step   = phase_nxt;
    rem_step  = chunk_remaining_nxt;
    emit_step = chunk_emitted_nxt;
    stop_step = stop_reason_nxt;

    // the final byte returns the decoder to its reset point
    if (last) begin
      phase_nxt           = PH_LINE;
      hex_value_nxt       = '0;
      hex_ended_nxt       = 1'b0;
      line_length_nxt     = '0;
      pending_cr_nxt      = 1'b0;
      chunk_remaining_nxt = '0;
      chunk_emitted_nxt   = '0;
      skip_left_nxt       = 2'd0;
      stop_reason_nxt     = ST_NOTERM;
    end
  end

  // result fields for the accepted byte
  always_comb begin
    res.out_valid     = (phase_r == PH_DATA);
    res.out_byte      = (phase_r == PH_DATA) ? c : 8'd0;
    res.body_done     = last;
    res.end_status    = ST_TERM;
    res.discard_count = '0;
    if (last) begin
      if (ph_step == PH_STOP) begin
        // covers a stop decided by this very byte
        res.end_status = stop_step;
      end else if (ph_step == PH_DATA && rem_step != '0) begin
        res.end_status    = ST_TRUNC;
        res.discard_count = DC_BITS'(emit_step);
      end else begin
        res.end_status = ST_NOTERM;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_LINE;
      hex_value_r       <= '0;
      hex_ended_r       <= 1'b0;
      line_length_r     <= '0;
      pending_cr_r      <= 1'b0;
      chunk_remaining_r <= '0;
      chunk_emitted_r   <= '0;
      skip_left_r       <= 2'd0;
      stop_reason_r     <= ST_NOTERM;
    end else if (accept) begin
      phase_r           <= phase_nxt;
      hex_value_r       <= hex_value_nxt;
      hex_ended_r       <= hex_ended_nxt;
      line_length_r     <= line_length_nxt;
      pending_cr_r      <= pending_cr_nxt;
      chunk_remaining_r <= chunk_remaining_nxt;
      chunk_emitted_r   <= chunk_emitted_nxt;
      skip_left_r       <= skip_left_nxt;
      stop_reason_r     <= stop_reason_nxt;
    end
  end

  // result register with skid register behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ch.ready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= accept;
      end
    end else if (accept) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ch.ready) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

`ifndef ASSERT_OFF
  // the skid register only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register holds a result while the result register is empty");

  // a chunk in progress always has payload left
  a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (chunk_remaining_r != '0))
    else $error("data phase with no chunk bytes remaining");

  // the final byte brings the decoder back to a fresh size line
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (phase_r == PH_LINE && hex_value_r == '0 &&
                          line_length_r == '0 && !pending_cr_r))
    else $error("decoder state not cleared after the final byte");

  // a stalled result is not overwritten
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |=> (out_vld_r && $stable(out_r)))
    else $error("result changed while the receiver stalled");
`endif

endmodule

`default_nettype wire

>>> tb/http_chunked_body_decoder_checker.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_checker
// watches both channels of the chunked body decoder, predicts the result of
// every accepted body byte and compares it field by field with the decoder
// ----------------------------------------------------------------------------

module http_chunked_body_decoder_checker import hcbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  hcbd_in_if   in_ch,
  hcbd_out_if  out_ch,
  output int   mismatches,
  output int   results_owed
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SIZE_BITS-1:0] SIZE_TOP = '1;

  // decode state
  phase_t               phase;
  logic [SIZE_BITS-1:0] size_acc;
  logic                 size_done;
  logic [LEN_BITS-1:0]  line_len;
  logic                 cr_seen;
  logic [SIZE_BITS-1:0] chunk_left;
  logic [DC_BITS-1:0]   chunk_sent;
  logic [1:0]           skip_left;
  status_t              stop_why;

  out_item_t decoded_q[$];

  function automatic void restart();
    phase      = PH_LINE;
    size_acc   = '0;
    size_done  = 1'b0;
    line_len   = '0;
    cr_seen    = 1'b0;
    chunk_left = '0;
    chunk_sent = '0;
    skip_left  = '0;
    stop_why   = ST_NOTERM;
  endfunction

  function automatic out_item_t decode_byte(logic [7:0] c, logic last);
    out_item_t  r;
    logic [3:0] nib;
    logic       is_digit;
    r = '0;
    case (phase)
      PH_LINE: begin
        if (cr_seen && c == CH_LF) begin
          cr_seen = 1'b0;
          if (line_len == 0 || line_len >= LINE_BUFFER_BYTES) begin
            phase    = PH_STOP;
            stop_why = ST_BAD;
          end else if (size_acc == 0) begin
            phase    = PH_STOP;
            stop_why = ST_TERM;
          end else begin
            phase      = PH_DATA;
            chunk_left = size_acc;
            chunk_sent = '0;
          end
          size_acc  = '0;
          size_done = 1'b0;
          line_len  = '0;
        end else begin
          // a held cr that is not followed by lf counts as a line byte
          if (cr_seen && line_len != LEN_CAP) line_len++;
          cr_seen = (c == CH_CR);
          if (c != CH_CR && line_len != LEN_CAP) line_len++;
          if (!size_done) begin
            is_digit = 1'b1;
            nib      = '0;
            if (c >= "0" && c <= "9") nib = c[3:0];
            else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) nib = c[3:0] + 4'd9;
            else is_digit = 1'b0;
            if (!is_digit) size_done = 1'b1;
            else if (size_acc > ((SIZE_TOP - nib) >> 4)) size_acc = SIZE_TOP;
            else size_acc = (size_acc << 4) + nib;
          end
        end
      end
      PH_DATA: begin
        r.out_byte  = c;
        r.out_valid = 1'b1;
        if (chunk_left != 0) chunk_left--;
        chunk_sent++;
        if (chunk_left == 0) begin
          phase     = PH_SKIP;
          skip_left = SKIP_BYTES;
        end
      end
      PH_SKIP: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) phase = PH_LINE;
      end
      default: ;
    endcase
    if (last) begin
      r.body_done = 1'b1;
      if (phase == PH_STOP) begin
        r.end_status = stop_why;
      end else if (phase == PH_DATA && chunk_left != 0) begin
        r.end_status    = ST_TRUNC;
        r.discard_count = chunk_sent;
      end else begin
        r.end_status = ST_NOTERM;
      end
      restart();
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0h actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      restart();
      decoded_q.delete();
      mismatches = 0;
    end else begin
      // compare before predicting: a result never belongs to the byte taken
      // at the same edge
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (decoded_q.size() == 0) begin
          $error("result transaction with nothing outstanding, out_byte %0h", got.out_byte);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
          check_field("out_valid", 32'(want.out_valid), 32'(got.out_valid));
          check_field("body_done", 32'(want.body_done), 32'(got.body_done));
          check_field("end_status", 32'(want.end_status), 32'(got.end_status));
          check_field("discard_count", want.discard_count, got.discard_count);
        end
      end
      if (in_ch.valid && in_ch.ready)
        decoded_q.push_back(decode_byte(in_ch.payload.in_byte, in_ch.payload.in_last));
    end
    results_owed = decoded_q.size();
  end

endmodule

>>> tb/tb_http_chunked_body_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder_top
// feeds chunked bodies to the decoder with random gaps and stalls; the
// checker beside the decoder predicts and compares every result
// ----------------------------------------------------------------------------

module tb_http_chunked_body_decoder_top import hcbd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int BODY_BYTES   = 700;  // random bytes to send
  localparam int QUIET_LIMIT  = 2000; // cycles with no transaction at all
  localparam int DRAIN_CYCLES = 8;    // extra wait once no result is owed

  logic clk;
  logic rst_n;
  bit   calm;          // no gaps and no stalls while set
  int   mismatches;
  int   results_owed;
  int   quiet_cycles;
  int   bytes_sent;
  int   body_count;

  logic [7:0] body[$]; // bytes of the body being built

  hcbd_in_if  in_ch();
  hcbd_out_if out_ch();

  http_chunked_body_decoder_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  http_chunked_body_decoder_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver: stalls about one cycle in nine, changes only at the falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever @(negedge clk) out_ch.ready <= calm || ($urandom_range(99) >= 11);
  end

  // watchdog: ends the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_http_chunked_body_decoder_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 10) return 8'h30 + v;
    return (upper ? 8'h37 : 8'h57) + v;
  endfunction

  // mostly line syntax, so noise still forms lines now and then
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(7))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return 8'h30;
      3, 4:    return hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_text(string s);
    for (int k = 0; k < s.len(); k++) body.push_back(s[k]);
  endtask

  task automatic add_crlf();
    body.push_back(CH_CR);
    body.push_back(CH_LF);
  endtask

  // size line with random case, optional leading zeros and extension
  task automatic add_size_line(int unsigned size);
    int         ndig;
    bit         upper;
    logic [7:0] x;
    ndig = 1;
    while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
    upper = 1'($urandom_range(1));
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) body.push_back("0");
    for (int k = ndig - 1; k >= 0; k--) body.push_back(hex_char(4'(size >> (4 * k)), upper));
    if ($urandom_range(4) == 0) begin
      body.push_back(";");
      repeat ($urandom_range(1, 6)) begin
        x = 8'($urandom_range(255));
        body.push_back(x == CH_CR ? 8'h3D : x);
      end
    end
    add_crlf();
  endtask

  task automatic build_random_body();
    int unsigned pick;
    int unsigned size;
    int unsigned cut;
    logic [7:0]  x;
    body.delete();
    pick = $urandom_range(99);
    if (pick < 65) begin
      // well-formed chunks, sometimes without terminator or cut short
      repeat ($urandom_range(3)) begin
        size = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        add_size_line(size);
        repeat (size) body.push_back(8'($urandom_range(255)));
        if ($urandom_range(7) == 0) repeat (2) body.push_back(noise_byte());
        else add_crlf();
      end
      if ($urandom_range(3) != 0) begin
        add_size_line(0);
        if ($urandom_range(1)) add_crlf();
        else repeat ($urandom_range(1, 4)) body.push_back(noise_byte());
      end
      if (body.size() > 1 && $urandom_range(2) == 0) begin
        cut = $urandom_range(1, body.size() - 1);
        while (body.size() > cut) void'(body.pop_back());
      end
    end else if (pick < 82) begin
      repeat ($urandom_range(1, 20)) body.push_back(noise_byte());
    end else if (pick < 90) begin
      // size line around the length limit, now and then past the counter cap
      body.push_back(hex_char(4'($urandom_range(1, 15)), 1'b0));
      repeat ($urandom_range(29, ($urandom_range(3) == 0) ? 70 : 34)) begin
        x = noise_byte();
        body.push_back(x == CH_CR ? 8'h2E : x);
      end
      add_crlf();
      repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(255)));
    end else begin
      // long hex sizes, most of them saturating
      body.push_back(hex_char(4'($urandom_range(1, 15)), 1'b1));
      repeat ($urandom_range(7, 15))
        body.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
      add_crlf();
      repeat ($urandom_range(1, 5)) body.push_back(8'($urandom_range(255)));
    end
    if (body.size() == 0) body.push_back(noise_byte());
  endtask

  // one byte per transaction; may idle first, returns at the falling edge
  // after the byte was taken
  task automatic send_byte(logic [7:0] b, logic last);
    while (!calm && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.payload.in_byte <= b;
    in_ch.payload.in_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_body();
    foreach (body[i]) send_byte(body[i], i == body.size() - 1);
    bytes_sent += body.size();
    body_count++;
  endtask

  initial begin
    rst_n         = 1'b0;
    calm          = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    bytes_sent    = 0;
    body_count    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero-size terminator, then trailer bytes that must be ignored
    body.delete(); add_text("1"); add_crlf(); add_text("A"); add_crlf();
    add_text("0"); add_crlf(); add_crlf(); add_text("t"); send_body();
    // size line still open at the final byte
    body.delete(); add_text("3"); send_body();
    // size line complete exactly at the final byte
    body.delete(); add_text("2"); add_crlf(); send_body();
    // extension ignored, chunk cut short after two payload bytes
    body.delete(); add_text("4;x"); add_crlf(); body.push_back(8'hFF); body.push_back(8'h00);
    send_body();
    // final byte among the two bytes after a chunk
    body.delete(); add_text("1"); add_crlf(); add_text("Z"); body.push_back(CH_CR); send_body();
    // final byte right after a full chunk
    body.delete(); add_text("1"); add_crlf(); add_text("Z"); send_body();
    // empty size line
    body.delete(); add_crlf(); send_body();
    // hex prefix reads as zero
    body.delete(); add_text("0x5"); add_crlf(); add_text("q"); send_body();
    // lone cr inside the size line
    body.delete(); add_text("1"); body.push_back(CH_CR); add_crlf(); add_text("y"); send_body();
    // size saturates
    body.delete(); add_text("FFFFFFFFF"); add_crlf(); add_text("a"); send_body();

    // random bodies, with a stretch free of gaps and stalls
    bytes_sent = 0;
    while (bytes_sent < BODY_BYTES) begin
      calm = (body_count >= 20 && body_count < 32);
      build_random_body();
      send_body();
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("tb_http_chunked_body_decoder_top: done, clean");
    else
      $display("tb_http_chunked_body_decoder_top: done, errors");
    $finish;
  end

endmodule
